FILE: src/keystream_byte_descrambler_defines.svh
// Assertion macros shared by the descrambler checker.
`ifndef KEYSTREAM_BYTE_DESCRAMBLER_DEFINES_SVH
`define KEYSTREAM_BYTE_DESCRAMBLER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define KBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KBD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/kbd_pkg.sv
// Types, constants and helper functions of the keystream byte descrambler.
`timescale 1ns / 1ps

package kbd_pkg;

	localparam int KEY_WORDS = 4;
	localparam int KEY_BITS  = KEY_WORDS * 64;

	localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [7:0]  POS_STEP    = 8'h9E;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
	localparam logic [1:0] REG_KEY_WORD_1 = 2'd1;
	localparam logic [1:0] REG_KEY_WORD_2 = 2'd2;
	localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

	typedef logic [KEY_BITS-1:0] kbd_key_t;

	// captured at the state update, waiting for the keystream mix
	typedef struct packed {
		logic [7:0] cipher;
		logic       last;
		logic [7:0] pos;
		logic [7:0] gen_byte;
	} kbd_item_t;

	function automatic logic [7:0] key_byte(input kbd_key_t key, input logic [4:0] idx);
		return key[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] amt);
		logic [15:0] w;
		w = {v, v} << amt;
		return w[15:8];
	endfunction

	function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] amt);
		logic [15:0] w;
		w = {v, v} >> amt;
		return w[7:0];
	endfunction

	function automatic logic [63:0] xorshift64(input logic [63:0] s);
		logic [63:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 7);
		x = x ^ (x << 17);
		return x;
	endfunction

endpackage

FILE: src/kbd_keyreg.sv
// Key register file written through the configuration port.
`timescale 1ns / 1ps

module kbd_keyreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [63:0]       cfg_wdata,
	output kbd_pkg::kbd_key_t key
);
	import kbd_pkg::*;

	logic [63:0] key_word_q [KEY_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < KEY_WORDS; w++) key_word_q[w] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY_WORD_0: key_word_q[0] <= cfg_wdata;
				REG_KEY_WORD_1: key_word_q[1] <= cfg_wdata;
				REG_KEY_WORD_2: key_word_q[2] <= cfg_wdata;
				REG_KEY_WORD_3: key_word_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign key = {key_word_q[3], key_word_q[2], key_word_q[1], key_word_q[0]};

endmodule

FILE: src/kbd_gen.sv
// Byte position counter and xorshift64 generator, advanced once per input beat.
`timescale 1ns / 1ps

module kbd_gen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        last,
	input  logic [63:0] seed,
	output logic [7:0]  pos,
	output logic [7:0]  gen_byte
);
	import kbd_pkg::*;

	logic [7:0]  byte_position_q;
	logic [63:0] gen_q;
	logic        fresh_q;
	logic [63:0] gen_base;
	logic [63:0] gen_next;

	// first byte of an asset starts from the seed; a zero seed is replaced
	assign gen_base = fresh_q ? ((seed != '0) ? seed : GOLDEN_SEED) : gen_q;
	assign gen_next = xorshift64(gen_base);
	assign pos      = byte_position_q;
	assign gen_byte = gen_next[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			gen_q           <= '0;
			fresh_q         <= 1'b1;
		end else if (advance) begin
			gen_q <= gen_next;
			if (last) begin
				byte_position_q <= '0;
				fresh_q         <= 1'b1;
			end else begin
				byte_position_q <= byte_position_q + 8'd1;
				fresh_q         <= 1'b0;
			end
		end
	end

endmodule

FILE: src/kbd_mix.sv
// Keystream byte formation and descrambling of one byte.
`timescale 1ns / 1ps

module kbd_mix (
	input  kbd_pkg::kbd_item_t item,
	input  kbd_pkg::kbd_key_t  key,
	output logic [7:0]         plain
);
	import kbd_pkg::*;

	logic [7:0] pos_mul;
	logic [7:0] rot_idx;
	logic [7:0] rot_key;
	logic [7:0] ks_sum;
	logic [7:0] ks_rot;

	assign pos_mul = item.pos * POS_STEP;
	assign ks_sum  = key_byte(key, item.pos[4:0]) + pos_mul;
	// (7i + 3) mod 32, only the low five bits matter
	assign rot_idx = item.pos * 8'd7 + 8'd3;
	assign rot_key = key_byte(key, rot_idx[4:0]);
	assign ks_rot  = rotl8(ks_sum, rot_key[2:0]);
	assign plain   = rotr8(item.cipher, item.pos[2:0]) ^ ks_rot ^ item.gen_byte;

endmodule

FILE: src/keystream_byte_descrambler.sv
// Path: an accepted byte is stored in item_s1, then mixed and registered in plain_q.
// Throughput: one byte per cycle unless the output stalls; the output register lets
// input continue while a finished byte waits; an output stall backs up after two beats.
// Reset: arst_n clears the key words, position, generator and all valid flags;
// the next byte after reset starts a new asset.
`timescale 1ns / 1ps

module keystream_byte_descrambler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] plain_byte
	output logic        m_tlast,   // final_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);
	import kbd_pkg::*;

	kbd_key_t  key;
	kbd_item_t item_in;
	kbd_item_t item_s1;
	logic      valid_s1;
	logic      accept;
	logic      out_ld;
	logic      out_valid_q;
	logic [7:0] plain_q;
	logic      last_q;
	logic [7:0] pos;
	logic [7:0] gen_byte;
	logic [7:0] plain;

	assign out_ld   = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_ld;
	assign accept   = s_tvalid && s_tready;

	kbd_keyreg u_keyreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.key      (key)
	);

	kbd_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.last    (s_tlast),
		.seed    (key[63:0]),
		.pos     (pos),
		.gen_byte(gen_byte)
	);

	always_comb begin
		item_in.cipher   = s_tdata;
		item_in.last     = s_tlast;
		item_in.pos      = pos;
		item_in.gen_byte = gen_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_ld) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item_in;
	end

	kbd_mix u_mix (
		.item (item_s1),
		.key  (key),
		.plain(plain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && valid_s1) begin
			plain_q <= plain;
			last_q  <= item_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = plain_q;
	assign m_tlast  = last_q;

endmodule

FILE: src/kbd_checker.sv
// Port-level checks of the descrambler and the bind that attaches them.
`timescale 1ns / 1ps
`include "keystream_byte_descrambler_defines.svh"

module kbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	`KBD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output beat dropped while stalled")
	`KBD_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")
	`KBD_ASSERT(a_ready_flow, m_tready |-> s_tready, "input blocked while output drains")
	`KBD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid, "output beat shown during reset")

endmodule

bind keystream_byte_descrambler kbd_checker u_kbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
